FILE: sv/ptd_pkg.sv
package ptd_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ACNT_W      = 7;

  // Request types
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [7:0]  vx;
    logic signed [7:0]  vy;
  } entry_t;

  typedef struct packed {
    entry_t ent;
    logic   keep;
  } upd_t;

  // Truncating divide by 5: magnitude times 205, shifted by 10, sign restored
  function automatic logic signed [7:0] div5(input logic signed [7:0] v);
    logic [7:0]  mag;
    logic [15:0] prod;
    logic [7:0]  q;
    begin
      mag  = v[7] ? (8'd0 - v) : v;
      prod = {8'd0, mag} * 16'd205;
      q    = {3'd0, prod[14:10]};
      div5 = v[7] ? $signed(8'd0 - q) : $signed(q);
    end
  endfunction

endpackage

FILE: sv/ptd_update.sv
module ptd_update (
  input  ptd_pkg::entry_t cur,
  output ptd_pkg::upd_t   upd
);

  logic signed [7:0] qx;
  logic signed [7:0] qy;
  logic signed [7:0] nvx;
  logic signed [7:0] nvy;

  // Advance position by velocity/5, wrapping at 16 bits
  assign qx = ptd_pkg::div5(cur.vx);
  assign qy = ptd_pkg::div5(cur.vy);
  assign upd.ent.px = cur.px + {{8{qx[7]}}, qx};
  assign upd.ent.py = cur.py + {{8{qy[7]}}, qy};

  // Step velocity toward zero; zero moves up to +1
  assign nvx = (cur.vx > 8'sd0) ? (cur.vx - 8'sd1) : (cur.vx + 8'sd1);
  assign nvy = (cur.vy > 8'sd0) ? (cur.vy - 8'sd1) : (cur.vy + 8'sd1);
  assign upd.ent.vx = nvx;
  assign upd.ent.vy = nvy;

  // Drop the particle once either slowed velocity divides to zero
  assign upd.keep = (ptd_pkg::div5(nvx) != 8'sd0) && (ptd_pkg::div5(nvy) != 8'sd0);

endmodule

FILE: sv/particle_table_decay_step_top.sv
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+------------------------------
// request   | in_req_type, in_pos_x/y, in_vel_x/y          | start & !busy
// result    | out_has_particle, out_x/y, out_accepted,     | out_valid, one cycle, no stall
//           | out_active_count, out_last                   |
//
// An add's result shows in the following cycle.
// A tick walks the N particles held at start, then reads out the S survivors:
// the single-port-read table handles one particle visit per cycle, then one
// survivor read per cycle. A tick that leaves no survivors ends with one result.
// Reset clears the particle count; table contents stay undefined until written.
// The receiver cannot stall: each result is valid for exactly one cycle.
module particle_table_decay_step_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_req_type,
  input  logic signed [15:0]                in_pos_x,
  input  logic signed [15:0]                in_pos_y,
  input  logic signed [7:0]                 in_vel_x,
  input  logic signed [7:0]                 in_vel_y,
  output logic                              out_valid,
  output logic                              out_has_particle,
  output logic signed [15:0]                out_x,
  output logic signed [15:0]                out_y,
  output logic                              out_accepted,
  output logic [ptd_pkg::ACNT_W-1:0]        out_active_count,
  output logic                              out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam int CW = ptd_pkg::CNT_W;
  localparam int IW = ptd_pkg::IDX_W;

  logic [1:0]    st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  logic          ov_r, ov_nxt;
  logic          has_r, has_nxt;
  logic          acc_r, acc_nxt;
  logic          last_r, last_nxt;
  logic [CW-1:0] ocnt_r, ocnt_nxt;

  ptd_pkg::entry_t mem [ptd_pkg::MAX_ENTRIES];
  ptd_pkg::entry_t rdata_r;
  ptd_pkg::entry_t wdata;
  logic [IW-1:0]   raddr;
  logic [IW-1:0]   waddr;
  logic            we;

  ptd_pkg::upd_t   upd;

  logic [CW-1:0]   idx_ext;
  logic [CW-1:0]   idx_inc;
  logic [CW-1:0]   cnt_dec;

  ptd_update u_update (
    .cur (rdata_r),
    .upd (upd)
  );

  assign idx_ext = CW'(idx_r);
  assign idx_inc = idx_ext + CW'(1);
  assign cnt_dec = cnt_r - CW'(1);

  // Sequence requests, table walk and survivor readout
  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    ov_nxt   = 1'b0;
    has_nxt  = 1'b0;
    acc_nxt  = 1'b0;
    last_nxt = 1'b0;
    ocnt_nxt = ocnt_r;
    raddr    = idx_r;
    waddr    = idx_r;
    wdata    = upd.ent;
    we       = 1'b0;
    case (st_r)
      ST_IDLE: begin
        raddr = '0;
        if (start) begin
          if (in_req_type == ptd_pkg::REQ_ADD) begin
            waddr = cnt_r[IW-1:0];
            wdata = '{px: in_pos_x, py: in_pos_y, vx: in_vel_x, vy: in_vel_y};
            ov_nxt   = 1'b1;
            last_nxt = 1'b1;
            if (cnt_r < CW'(ptd_pkg::MAX_ENTRIES)) begin
              we       = 1'b1;
              acc_nxt  = 1'b1;
              cnt_nxt  = cnt_r + CW'(1);
            end
            ocnt_nxt = acc_nxt ? cnt_nxt : cnt_r;
          end else if (cnt_r == '0) begin
            ov_nxt   = 1'b1;
            last_nxt = 1'b1;
            ocnt_nxt = '0;
          end else begin
            idx_nxt = '0;
            st_nxt  = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (upd.keep) begin
          // Write back the survivor and advance
          we = 1'b1;
          if (idx_inc < cnt_r) begin
            idx_nxt = idx_inc[IW-1:0];
            raddr   = idx_inc[IW-1:0];
          end else begin
            idx_nxt = '0;
            st_nxt  = ST_EMIT;
          end
        end else begin
          // Drop: pull the last entry into this slot and process it next
          cnt_nxt = cnt_dec;
          if (idx_ext < cnt_dec) begin
            raddr = cnt_dec[IW-1:0];
          end else if (cnt_dec == '0) begin
            ov_nxt   = 1'b1;
            last_nxt = 1'b1;
            ocnt_nxt = '0;
            st_nxt   = ST_IDLE;
          end else begin
            idx_nxt = '0;
            st_nxt  = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        raddr    = idx_r;
        ov_nxt   = 1'b1;
        has_nxt  = 1'b1;
        ocnt_nxt = cnt_r;
        if (idx_inc == cnt_r) begin
          last_nxt = 1'b1;
          st_nxt   = ST_IDLE;
        end else begin
          idx_nxt = idx_inc[IW-1:0];
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // Register result payload
  always_ff @(posedge clk) begin
    has_r  <= has_nxt;
    acc_r  <= acc_nxt;
    last_r <= last_nxt;
    ocnt_r <= ocnt_nxt;
  end

  // Particle table: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign busy             = (st_r != ST_IDLE);
  assign out_valid        = ov_r;
  assign out_has_particle = has_r;
  assign out_x            = has_r ? rdata_r.px : 16'sd0;
  assign out_y            = has_r ? rdata_r.py : 16'sd0;
  assign out_accepted     = acc_r;
  assign out_active_count = ptd_pkg::ACNT_W'(ocnt_r);
  assign out_last         = last_r;

  a_surv_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_particle |-> !out_accepted)
    else $error("survivor result flagged as accepted add");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && out_has_particle)
    else $error("survivor burst broken before last");

  a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_WALK |-> idx_ext < cnt_r)
    else $error("walk index beyond particle count");

  a_surv_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_particle |-> out_active_count != '0)
    else $error("survivor reported with empty table");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ptd_pkg::MAX_ENTRIES))
    else $error("particle count above capacity");

endmodule
